// ----- rtl/fpcd_pkg.sv -----
// Package for the FLIC pixel chunk decoder.
// Holds the parse phase codes, dimension constants and the span record type.
// Used by all modules under rtl; depends on nothing.
package fpcd_pkg;

   localparam int MaxDim = 4096;
   localparam int DimW = $clog2(MaxDim) + 1;

   localparam logic [2:0] FUNC_BRUN  = 3'd0;
   localparam logic [2:0] FUNC_LC    = 3'd1;
   localparam logic [2:0] FUNC_SS2   = 3'd2;
   localparam logic [2:0] FUNC_COPY  = 3'd3;
   localparam logic [2:0] FUNC_BLACK = 3'd4;

   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_BR_ROW  = 5'd1;
   localparam logic [4:0] PH_BR_CNT  = 5'd2;
   localparam logic [4:0] PH_BR_VAL  = 5'd3;
   localparam logic [4:0] PH_BR_LIT  = 5'd4;
   localparam logic [4:0] PH_LC_H0   = 5'd5;
   localparam logic [4:0] PH_LC_H1   = 5'd6;
   localparam logic [4:0] PH_LC_H2   = 5'd7;
   localparam logic [4:0] PH_LC_H3   = 5'd8;
   localparam logic [4:0] PH_LC_PKTS = 5'd9;
   localparam logic [4:0] PH_LC_SKIP = 5'd10;
   localparam logic [4:0] PH_LC_CNT  = 5'd11;
   localparam logic [4:0] PH_LC_VAL  = 5'd12;
   localparam logic [4:0] PH_LC_LIT  = 5'd13;
   localparam logic [4:0] PH_SS_H0   = 5'd14;
   localparam logic [4:0] PH_SS_H1   = 5'd15;
   localparam logic [4:0] PH_SS_OPLO = 5'd16;
   localparam logic [4:0] PH_SS_OPHI = 5'd17;
   localparam logic [4:0] PH_SS_SKIP = 5'd18;
   localparam logic [4:0] PH_SS_CNT  = 5'd19;
   localparam logic [4:0] PH_SS_RA   = 5'd20;
   localparam logic [4:0] PH_SS_RB   = 5'd21;
   localparam logic [4:0] PH_SS_LA   = 5'd22;
   localparam logic [4:0] PH_SS_LB   = 5'd23;
   localparam logic [4:0] PH_COPY    = 5'd24;

   typedef struct packed {
      logic [11:0] row;
      logic [11:0] column;
      logic [8:0]  span_length;
      logic [7:0]  value_first;
      logic [7:0]  value_second;
      logic        alternate;
      logic        clear_all;
      logic        row_error;
   } span_type;

   localparam int SpanW = $bits(span_type);

endpackage

// ----- rtl/fpcd_parser.sv -----
// Front part of the FLIC pixel chunk decoder: byte parser and span builder.
// Produces at most one span record per accepted byte. Uses fpcd_pkg.
module fpcd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [2:0]           func,
   input  logic                 chunk_start,
   input  logic [7:0]           data_byte,
   input  logic [12:0]          width_raw,
   input  logic [12:0]          height_raw,
   output logic                 emit,
   output fpcd_pkg::span_type   span_out
);
   import fpcd_pkg::*;

   logic [4:0]  phase_ff, phase_in;
   logic [15:0] row_ff, row_in;
   logic [12:0] col_ff, col_in;
   logic [15:0] lines_ff, lines_in;
   logic [15:0] pkts_ff, pkts_in;
   logic [8:0]  bytes_ff, bytes_in;
   logic [7:0]  held_ff, held_in;
   logic        err_ff, err_in;

   logic [12:0] w, h;
   logic [15:0] op;

   function automatic logic [12:0] clampd(input logic [12:0] v);
      if (v == 13'd0) return 13'd1;
      if (v > 13'(MaxDim)) return 13'(MaxDim);
      return v;
   endfunction

   function automatic logic [12:0] cadd(input logic [12:0] c, input logic [9:0] n);
      logic [13:0] s;
      s = {1'b0, c} + {4'd0, n};
      if (s > 14'(MaxDim)) return 13'(MaxDim);
      return s[12:0];
   endfunction

   function automatic logic [15:0] radd(input logic [15:0] r, input logic [16:0] n);
      logic [17:0] s;
      s = {2'b0, r} + {1'b0, n};
      if (s > 18'hFFFF) return 16'hFFFF;
      return s[15:0];
   endfunction

   always_comb begin
      logic [9:0]  len;
      logic        want;
      logic [7:0]  v1, v2;
      logic        alt;
      logic [12:0] room;
      logic [4:0]  ph;
      logic [15:0] rr;
      logic [12:0] cc;
      logic [15:0] ll, pp;
      logic [8:0]  bb;
      logic [7:0]  hh;
      logic        ee;
      logic        errout;
      logic        clr;
      logic [12:0] scol;
      logic [15:0] srow;

      w = clampd(width_raw);
      h = clampd(height_raw);
      op = {data_byte, held_ff};
      ph = phase_ff; rr = row_ff; cc = col_ff; ll = lines_ff; pp = pkts_ff;
      bb = bytes_ff; hh = held_ff; ee = err_ff;
      want = 1'b0; len = '0; v1 = '0; v2 = '0; alt = 1'b0;
      errout = 1'b0; clr = 1'b0;
      emit = 1'b0; span_out = '0;
      scol = '0; srow = '0; room = '0;

      if (chunk_start) begin
         rr = '0; cc = '0; ll = '0; pp = '0; bb = '0; hh = '0; ee = 1'b0;
         unique case (func)
            FUNC_BRUN:  ph = PH_BR_ROW;
            FUNC_LC:    ph = PH_LC_H0;
            FUNC_SS2:   ph = PH_SS_H0;
            FUNC_COPY:  ph = PH_COPY;
            FUNC_BLACK: begin ph = PH_IDLE; clr = 1'b1; end
            default:    ph = PH_IDLE;
         endcase
      end

      if (!ee && !clr && !(chunk_start && func > FUNC_COPY)) begin
         scol = cc; srow = rr;
         unique case (ph)
            PH_BR_ROW: begin cc = '0; ph = PH_BR_CNT; end
            PH_BR_CNT: begin
               if (!data_byte[7]) begin bb = {1'b0, data_byte}; ph = PH_BR_VAL; end
               else begin bb = 9'd256 - {1'b0, data_byte}; ph = PH_BR_LIT; end
            end
            PH_BR_VAL, PH_BR_LIT: begin
               want = 1'b1; v1 = data_byte;
               if (ph == PH_BR_VAL) begin
                  len = {1'b0, bb};
               end else begin
                  len = 10'd1; bb = bb - 9'd1;
               end
               cc = cadd(cc, len);
               if (ph == PH_BR_VAL || bb == 9'd0) begin
                  if (cc >= w) begin
                     rr = radd(rr, 17'd1);
                     ph = (rr >= {3'd0, h}) ? PH_IDLE : PH_BR_ROW;
                  end else ph = PH_BR_CNT;
               end
            end
            PH_LC_H0, PH_LC_H2, PH_SS_H0, PH_SS_OPLO, PH_SS_RA, PH_SS_LA: begin
               hh = data_byte;
               unique case (ph)
                  PH_LC_H0:   ph = PH_LC_H1;
                  PH_LC_H2:   ph = PH_LC_H3;
                  PH_SS_H0:   ph = PH_SS_H1;
                  PH_SS_OPLO: ph = PH_SS_OPHI;
                  PH_SS_RA:   ph = PH_SS_RB;
                  default:    ph = PH_SS_LB;
               endcase
            end
            PH_LC_H1: begin rr = op; ph = PH_LC_H2; end
            PH_LC_H3, PH_SS_H1: begin
               ll = op;
               ph = (op == 16'd0) ? PH_IDLE : ((ph == PH_LC_H3) ? PH_LC_PKTS : PH_SS_OPLO);
            end
            PH_LC_PKTS: begin
               if (rr >= {3'd0, h}) errout = 1'b1;
               else begin
                  pp = {8'd0, data_byte}; cc = '0;
                  if (data_byte == 8'd0) begin
                     rr = radd(rr, 17'd1); ll = ll - 16'd1;
                     ph = (ll == 16'd0) ? PH_IDLE : PH_LC_PKTS;
                  end else ph = PH_LC_SKIP;
               end
            end
            PH_LC_SKIP, PH_SS_SKIP: begin
               cc = cadd(cc, {2'd0, data_byte});
               ph = (ph == PH_LC_SKIP) ? PH_LC_CNT : PH_SS_CNT;
            end
            PH_LC_CNT, PH_SS_CNT: begin
               if (data_byte == 8'd0) begin
                  pp = pp - 16'd1;
                  if (pp == 16'd0) begin
                     rr = radd(rr, 17'd1); ll = ll - 16'd1;
                     ph = (ll == 16'd0) ? PH_IDLE :
                          ((ph == PH_LC_CNT) ? PH_LC_PKTS : PH_SS_OPLO);
                  end else ph = (ph == PH_LC_CNT) ? PH_LC_SKIP : PH_SS_SKIP;
               end else if (!data_byte[7]) begin
                  bb = {1'b0, data_byte};
                  ph = (ph == PH_LC_CNT) ? PH_LC_LIT : PH_SS_LA;
               end else begin
                  bb = 9'd256 - {1'b0, data_byte};
                  ph = (ph == PH_LC_CNT) ? PH_LC_VAL : PH_SS_RA;
               end
            end
            PH_LC_VAL, PH_LC_LIT, PH_SS_RB, PH_SS_LB: begin
               want = 1'b1;
               if (ph == PH_SS_RB || ph == PH_SS_LB) begin
                  alt = 1'b1; v1 = hh; v2 = data_byte;
               end else v1 = data_byte;
               unique case (ph)
                  PH_LC_VAL: len = {1'b0, bb};
                  PH_LC_LIT: len = 10'd1;
                  PH_SS_RB:  len = {bb, 1'b0};
                  default:   len = 10'd2;
               endcase
               cc = cadd(cc, len);
               if (ph == PH_LC_LIT || ph == PH_SS_LB) bb = bb - 9'd1;
               if (ph == PH_LC_VAL || ph == PH_SS_RB || bb == 9'd0) begin
                  pp = pp - 16'd1;
                  if (pp == 16'd0) begin
                     rr = radd(rr, 17'd1); ll = ll - 16'd1;
                     ph = (ll == 16'd0) ? PH_IDLE :
                          ((ph == PH_LC_VAL || ph == PH_LC_LIT) ? PH_LC_PKTS : PH_SS_OPLO);
                  end else ph = (ph == PH_LC_VAL || ph == PH_LC_LIT) ? PH_LC_SKIP : PH_SS_SKIP;
               end else if (ph == PH_SS_LB) ph = PH_SS_LA;
            end
            PH_SS_OPHI: begin
               ph = PH_SS_OPLO;
               if (op[15:14] == 2'b11) begin
                  rr = radd(rr, 17'h10000 - {1'b0, op});
               end else if (op[15:14] == 2'b10) begin
                  if (rr < {3'd0, h}) begin
                     cc = w - 13'd1; scol = cc;
                     want = 1'b1; len = 10'd1; v1 = op[7:0];
                  end
               end else if (rr >= {3'd0, h}) errout = 1'b1;
               else begin
                  pp = op; cc = '0;
                  if (op == 16'd0) begin
                     rr = radd(rr, 17'd1); ll = ll - 16'd1;
                     ph = (ll == 16'd0) ? PH_IDLE : PH_SS_OPLO;
                  end else ph = PH_SS_SKIP;
               end
            end
            PH_COPY: begin
               if (rr < {3'd0, h}) begin
                  want = 1'b1; len = 10'd1; v1 = data_byte;
                  cc = cadd(cc, 10'd1);
                  if (cc >= w) begin cc = '0; rr = radd(rr, 17'd1); end
               end
            end
            default: ;
         endcase

         if (errout) begin
            ee = 1'b1; ph = PH_IDLE;
            emit = 1'b1;
            span_out.row = (rr > 16'd4095) ? 12'hFFF : rr[11:0];
            span_out.row_error = 1'b1;
         end else if (want && scol < w && len != 10'd0) begin
            room = w - scol;
            emit = 1'b1;
            span_out.row = srow[11:0];
            span_out.column = scol[11:0];
            span_out.span_length = ({3'd0, len} > room) ? room[8:0] : len[8:0];
            span_out.value_first = v1;
            span_out.value_second = v2;
            span_out.alternate = alt;
         end
      end else if (clr) begin
         emit = 1'b1;
         span_out.clear_all = 1'b1;
      end

      phase_in = ph; row_in = rr; col_in = cc; lines_in = ll; pkts_in = pp;
      bytes_in = bb; held_in = hh; err_in = ee;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; row_ff <= '0; col_ff <= '0; lines_ff <= '0;
         pkts_ff <= '0; bytes_ff <= '0; held_ff <= '0; err_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; row_ff <= row_in; col_ff <= col_in;
         lines_ff <= lines_in; pkts_ff <= pkts_in; bytes_ff <= bytes_in;
         held_ff <= held_in; err_ff <= err_in;
      end
   end
endmodule

// ----- rtl/fpcd_queue.sv -----
// Span queue between parser and output side of the FLIC chunk decoder.
// Four-entry FIFO of span records with registered head. Uses fpcd_pkg.
module fpcd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fpcd_pkg::span_type   push_data,
   output logic                 almost_full,
   output logic                 head_valid,
   output fpcd_pkg::span_type   head_data,
   input  logic                 pop
);
   import fpcd_pkg::*;

   span_type    mem_ff [4];
   logic [1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]  cnt_ff, cnt_in;

   always_comb begin
      wp_in = wp_ff + (push ? 2'd1 : 2'd0);
      rp_in = rp_ff + (pop ? 2'd1 : 2'd0);
      cnt_in = cnt_ff + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   assign head_valid = cnt_ff != 3'd0;
   assign head_data = mem_ff[rp_ff];
   assign almost_full = cnt_ff >= 3'd3;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- rtl/flic_pixel_chunk_decoder_unit.sv -----
// Top level of the FLIC pixel chunk decoder.
// Instantiates fpcd_parser and fpcd_queue; uses fpcd_pkg.
//
// The req channel carries one chunk payload byte per item with its chunk
// kind and a start flag; the rsp channel carries canvas span writes, a
// clear request for black chunks, or a row error flag. Both channels use
// valid and stall; an item moves at an edge where valid is high and stall
// is low. The csr port writes frame_width (index 0) and frame_height
// (index 1) at any edge where csr_write is high.
// Each byte is parsed in the cycle it is accepted and yields zero or one
// span, which is registered into a four-entry queue and offered on rsp
// once the spans ahead of it have left; one byte is taken per cycle while
// req_stall is low. req_stall rises when the queue holds three or more
// spans, so a stalled receiver stops input once three spans are queued.
// Synchronous reset empties the queue, sets the parser idle and loads
// width 320 and height 200; no clearing pass is needed.
module flic_pixel_chunk_decoder_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [2:0]   req_func,
   input  logic         req_chunk_start,
   input  logic [7:0]   req_data_byte,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [11:0]  rsp_row,
   output logic [11:0]  rsp_column,
   output logic [8:0]   rsp_span_length,
   output logic [7:0]   rsp_value_first,
   output logic [7:0]   rsp_value_second,
   output logic         rsp_alternate,
   output logic         rsp_clear_all,
   output logic         rsp_row_error,
   input  logic         csr_write,
   input  logic [0:0]   csr_index,
   input  logic [12:0]  csr_data
);
   import fpcd_pkg::*;

   logic [12:0] width_ff, height_ff;
   logic        step, emit, full;
   span_type    sp, head;

   assign step = req_valid && !req_stall;
   assign req_stall = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd320; height_ff <= 13'd200;
      end else if (csr_write) begin
         if (csr_index == CSR_WIDTH) width_ff <= csr_data;
         else height_ff <= csr_data;
      end
   end

   fpcd_parser u_parser (
      .clock(clock), .reset(reset), .step(step), .func(req_func),
      .chunk_start(req_chunk_start), .data_byte(req_data_byte),
      .width_raw(width_ff), .height_raw(height_ff), .emit(emit), .span_out(sp)
   );

   fpcd_queue u_queue (
      .clock(clock), .reset(reset), .push(step && emit), .push_data(sp),
      .almost_full(full), .head_valid(rsp_valid), .head_data(head),
      .pop(rsp_valid && !rsp_stall)
   );

   assign rsp_row = head.row;
   assign rsp_column = head.column;
   assign rsp_span_length = head.span_length;
   assign rsp_value_first = head.value_first;
   assign rsp_value_second = head.value_second;
   assign rsp_alternate = head.alternate;
   assign rsp_clear_all = head.clear_all;
   assign rsp_row_error = head.row_error;
endmodule

// ----- bench/flic_pixel_chunk_decoder_unit_tb.sv -----
// Self-checking testbench for flic_pixel_chunk_decoder_unit: a directed table of chunk bytes,
// then random chunks, mostly well-formed, under several canvas sizes and handshake idling patterns.
// Depends on fpcd_pkg and the RTL under rtl only.
module flic_pixel_chunk_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpcd_pkg::*;

   localparam int ExpNone  = 1;
   localparam int ExpTyped = 2;
   localparam int ExpModel = 0;

   typedef struct {
      logic [2:0] func;
      logic       start;
      logic [7:0] data;
   } chunk_byte_type;

   typedef struct {
      logic [2:0] func;
      logic       start;
      logic [7:0] data;
      int         how;
      span_type   span;
   } table_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic        req_chunk_start = 0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [11:0] rsp_row;
   logic [11:0] rsp_column;
   logic [8:0]  rsp_span_length;
   logic [7:0]  rsp_value_first;
   logic [7:0]  rsp_value_second;
   logic        rsp_alternate;
   logic        rsp_clear_all;
   logic        rsp_row_error;
   logic        csr_write = 0;
   logic [0:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   flic_pixel_chunk_decoder_unit dut (.*);

   always #1 clock = ~clock;

   // Decoder state mirrored by the span predictor.
   logic [12:0] cfg_width, cfg_height;
   logic [4:0]  phase;
   int unsigned cur_row, cur_col, lines_left, packets_left, run_left, held;
   bit          err_latched;

   span_type    span_queue[$];
   int          mismatches = 0;
   int          items_sent = 0;
   int          spans_seen = 0;
   int          chunks_sent = 0;
   bit          sender_idles = 0;
   bit          receiver_stalls = 0;
   int          idle_pct = 58;

   function automatic int unsigned clamp_dim(logic [12:0] v);
      if (v < 1) return 1;
      if (v > MaxDim) return MaxDim;
      return v;
   endfunction

   function automatic bit make_span(int unsigned len, int unsigned v1, int unsigned v2,
                                    bit alt, output span_type s);
      int unsigned w;
      w = clamp_dim(cfg_width);
      s = '0;
      if (cur_col >= w || len == 0) return 0;
      if (len > w - cur_col) len = w - cur_col;
      s.row = cur_row[11:0];
      s.column = cur_col[11:0];
      s.span_length = len[8:0];
      s.value_first = v1[7:0];
      s.value_second = alt ? v2[7:0] : 8'd0;
      s.alternate = alt;
      return 1;
   endfunction

   function automatic void advance_col(int unsigned n);
      cur_col += n;
      if (cur_col > MaxDim) cur_col = MaxDim;
   endfunction

   function automatic void advance_row(int unsigned n);
      cur_row += n;
      if (cur_row > 16'hFFFF) cur_row = 16'hFFFF;
   endfunction

   function automatic bit flag_row_error(output span_type s);
      s = '0;
      s.row = (cur_row > 4095) ? 12'd4095 : cur_row[11:0];
      s.row_error = 1;
      err_latched = 1;
      phase = PH_IDLE;
      return 1;
   endfunction

   function automatic void brun_row_end();
      if (cur_col >= clamp_dim(cfg_width)) begin
         advance_row(1);
         phase = (cur_row >= clamp_dim(cfg_height)) ? PH_IDLE : PH_BR_ROW;
      end else begin
         phase = PH_BR_CNT;
      end
   endfunction

   function automatic void finish_line(logic [4:0] next);
      advance_row(1);
      lines_left = (lines_left - 1) & 16'hFFFF;
      phase = (lines_left == 0) ? PH_IDLE : next;
   endfunction

   function automatic void finish_packet(logic [4:0] line_next, logic [4:0] skip_next);
      packets_left = (packets_left - 1) & 16'hFFFF;
      if (packets_left == 0) finish_line(line_next);
      else phase = skip_next;
   endfunction

   function automatic bit predict_span(logic [2:0] func, logic start, logic [7:0] b,
                                       output span_type s);
      int unsigned h, w, op;
      bit got;
      h = clamp_dim(cfg_height);
      w = clamp_dim(cfg_width);
      got = 0;
      s = '0;
      if (start) begin
         cur_row = 0;
         cur_col = 0;
         lines_left = 0;
         packets_left = 0;
         run_left = 0;
         held = 0;
         err_latched = 0;
         case (func)
            FUNC_BRUN: phase = PH_BR_ROW;
            FUNC_LC:   phase = PH_LC_H0;
            FUNC_SS2:  phase = PH_SS_H0;
            FUNC_COPY: phase = PH_COPY;
            FUNC_BLACK: begin
               phase = PH_IDLE;
               s.clear_all = 1;
               return 1;
            end
            default: begin
               phase = PH_IDLE;
               return 0;
            end
         endcase
      end
      if (err_latched) return 0;
      case (phase)
         PH_BR_ROW: begin
            cur_col = 0;
            phase = PH_BR_CNT;
         end
         PH_BR_CNT: begin
            if (b < 8'h80) begin
               run_left = b;
               phase = PH_BR_VAL;
            end else begin
               run_left = 256 - b;
               phase = PH_BR_LIT;
            end
         end
         PH_BR_VAL: begin
            got = make_span(run_left, b, 0, 0, s);
            advance_col(run_left);
            brun_row_end();
         end
         PH_BR_LIT: begin
            got = make_span(1, b, 0, 0, s);
            advance_col(1);
            run_left--;
            if (run_left == 0) brun_row_end();
         end
         PH_LC_H0: begin
            held = b;
            phase = PH_LC_H1;
         end
         PH_LC_H1: begin
            cur_row = held | (b << 8);
            phase = PH_LC_H2;
         end
         PH_LC_H2: begin
            held = b;
            phase = PH_LC_H3;
         end
         PH_LC_H3: begin
            lines_left = held | (b << 8);
            phase = (lines_left == 0) ? PH_IDLE : PH_LC_PKTS;
         end
         PH_LC_PKTS: begin
            if (cur_row >= h) return flag_row_error(s);
            packets_left = b;
            cur_col = 0;
            if (b == 0) finish_line(PH_LC_PKTS);
            else phase = PH_LC_SKIP;
         end
         PH_LC_SKIP: begin
            advance_col(b);
            phase = PH_LC_CNT;
         end
         PH_LC_CNT: begin
            if (b == 0) begin
               finish_packet(PH_LC_PKTS, PH_LC_SKIP);
            end else if (b < 8'h80) begin
               run_left = b;
               phase = PH_LC_LIT;
            end else begin
               run_left = 256 - b;
               phase = PH_LC_VAL;
            end
         end
         PH_LC_VAL: begin
            got = make_span(run_left, b, 0, 0, s);
            advance_col(run_left);
            finish_packet(PH_LC_PKTS, PH_LC_SKIP);
         end
         PH_LC_LIT: begin
            got = make_span(1, b, 0, 0, s);
            advance_col(1);
            run_left--;
            if (run_left == 0) finish_packet(PH_LC_PKTS, PH_LC_SKIP);
         end
         PH_SS_H0: begin
            held = b;
            phase = PH_SS_H1;
         end
         PH_SS_H1: begin
            lines_left = held | (b << 8);
            phase = (lines_left == 0) ? PH_IDLE : PH_SS_OPLO;
         end
         PH_SS_OPLO: begin
            held = b;
            phase = PH_SS_OPHI;
         end
         PH_SS_OPHI: begin
            op = held | (b << 8);
            phase = PH_SS_OPLO;
            if ((op & 16'hC000) == 16'hC000) begin
               advance_row(32'h10000 - op);
            end else if ((op & 16'hC000) == 16'h8000) begin
               if (cur_row < h) begin
                  cur_col = w - 1;
                  got = make_span(1, op & 8'hFF, 0, 0, s);
               end
            end else begin
               if (cur_row >= h) return flag_row_error(s);
               packets_left = op;
               cur_col = 0;
               if (op == 0) finish_line(PH_SS_OPLO);
               else phase = PH_SS_SKIP;
            end
         end
         PH_SS_SKIP: begin
            advance_col(b);
            phase = PH_SS_CNT;
         end
         PH_SS_CNT: begin
            if (b == 0) begin
               finish_packet(PH_SS_OPLO, PH_SS_SKIP);
            end else if (b < 8'h80) begin
               run_left = b;
               phase = PH_SS_LA;
            end else begin
               run_left = 256 - b;
               phase = PH_SS_RA;
            end
         end
         PH_SS_RA: begin
            held = b;
            phase = PH_SS_RB;
         end
         PH_SS_RB: begin
            got = make_span(2 * run_left, held, b, 1, s);
            advance_col(2 * run_left);
            finish_packet(PH_SS_OPLO, PH_SS_SKIP);
         end
         PH_SS_LA: begin
            held = b;
            phase = PH_SS_LB;
         end
         PH_SS_LB: begin
            got = make_span(2, held, b, 1, s);
            advance_col(2);
            run_left--;
            if (run_left == 0) finish_packet(PH_SS_OPLO, PH_SS_SKIP);
            else phase = PH_SS_LA;
         end
         PH_COPY: begin
            if (cur_row < h) begin
               got = make_span(1, b, 0, 0, s);
               advance_col(1);
               if (cur_col >= w) begin
                  cur_col = 0;
                  advance_row(1);
               end
            end
         end
         default: ;
      endcase
      return got;
   endfunction

   task automatic send_byte(logic [2:0] f, logic st, logic [7:0] b, int how, span_type typed);
      span_type s;
      bit got;
      @(negedge clock);
      if (sender_idles && $urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1;
      req_func <= f;
      req_chunk_start <= st;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      got = predict_span(f, st, b, s);
      if (how == ExpTyped) span_queue = {span_queue, typed};
      else if (how == ExpModel && got) span_queue = {span_queue, s};
      items_sent++;
      if (st) chunks_sent++;
   endtask

   task automatic write_csr(logic [0:0] idx, logic [12:0] v);
      @(negedge clock);
      req_valid <= 0;
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= v;
      if (idx == CSR_WIDTH) cfg_width = v;
      else cfg_height = v;
      @(negedge clock);
      csr_write <= 0;
   endtask

   task automatic drain();
      int n;
      n = 0;
      while (span_queue.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic send_chunk(const ref chunk_byte_type q[$]);
      foreach (q[i]) send_byte(q[i].func, q[i].start, q[i].data, ExpModel, '0);
   endtask

   task automatic add_byte(ref chunk_byte_type q[$], input logic [2:0] f, input int b);
      chunk_byte_type c;
      c.start = (q.size() == 0);
      c.func = c.start ? f : 3'($urandom_range(7));
      c.data = b[7:0];
      q = {q, c};
   endtask

   task automatic add_word(ref chunk_byte_type q[$], input logic [2:0] f, input int v);
      add_byte(q, f, v & 8'hFF);
      add_byte(q, f, (v >> 8) & 8'hFF);
   endtask

   task automatic random_chunk();
      chunk_byte_type q[$];
      int w, h, k, n, c, lines, pk;
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      k = $urandom_range(99);
      if (k < 22) begin
         for (int r = 0; r < h && q.size() < 90; r++) begin
            add_byte(q, FUNC_BRUN, $urandom_range(255));
            c = 0;
            while (c < w && q.size() < 90) begin
               n = $urandom_range(20);
               if ($urandom_range(1)) begin
                  add_byte(q, FUNC_BRUN, n);
                  add_byte(q, FUNC_BRUN, $urandom_range(255));
               end else begin
                  if (n == 0) n = 1;
                  add_byte(q, FUNC_BRUN, 256 - n);
                  repeat (n) add_byte(q, FUNC_BRUN, $urandom_range(255));
               end
               c += n;
            end
         end
      end else if (k < 44) begin
         add_word(q, FUNC_LC, $urandom_range(h + 1));
         lines = $urandom_range(3);
         add_word(q, FUNC_LC, lines);
         repeat (lines) begin
            pk = $urandom_range(3);
            add_byte(q, FUNC_LC, pk);
            repeat (pk) begin
               add_byte(q, FUNC_LC, $urandom_range(12));
               n = $urandom_range(8);
               case ($urandom_range(2))
                  0: add_byte(q, FUNC_LC, 0);
                  1: begin
                     add_byte(q, FUNC_LC, n + 1);
                     repeat (n + 1) add_byte(q, FUNC_LC, $urandom_range(255));
                  end
                  default: begin
                     add_byte(q, FUNC_LC, 255 - n);
                     add_byte(q, FUNC_LC, $urandom_range(255));
                  end
               endcase
            end
         end
      end else if (k < 70) begin
         lines = $urandom_range(3);
         add_word(q, FUNC_SS2, lines);
         repeat (lines) begin
            if ($urandom_range(3) == 0) add_word(q, FUNC_SS2, 32'h10000 - $urandom_range(1, 3));
            if ($urandom_range(3) == 0) add_word(q, FUNC_SS2, 16'h8000 | $urandom_range(255));
            pk = ($urandom_range(19) == 0) ? (16'h4000 | $urandom_range(16'h3FFF))
                                           : $urandom_range(3);
            add_word(q, FUNC_SS2, pk);
            if (pk > 3) pk = 2;
            repeat (pk) begin
               add_byte(q, FUNC_SS2, $urandom_range(12));
               n = $urandom_range(3);
               case ($urandom_range(2))
                  0: add_byte(q, FUNC_SS2, 0);
                  1: begin
                     add_byte(q, FUNC_SS2, n + 1);
                     repeat (2 * (n + 1)) add_byte(q, FUNC_SS2, $urandom_range(255));
                  end
                  default: begin
                     add_byte(q, FUNC_SS2, 255 - n);
                     repeat (2) add_byte(q, FUNC_SS2, $urandom_range(255));
                  end
               endcase
            end
         end
      end else if (k < 84) begin
         n = (w * h > 60) ? 60 : w * h;
         repeat (n + $urandom_range(3)) add_byte(q, FUNC_COPY, $urandom_range(255));
      end else if (k < 90) begin
         repeat (1 + $urandom_range(3)) add_byte(q, FUNC_BLACK, $urandom_range(255));
      end else if (k < 94) begin
         repeat (1 + $urandom_range(3)) add_byte(q, 3'($urandom_range(5, 7)), $urandom_range(255));
      end else begin
         repeat (1 + $urandom_range(5)) begin
            chunk_byte_type c2;
            c2.func = 3'($urandom_range(7));
            c2.start = $urandom_range(1);
            c2.data = 8'($urandom_range(255));
            q = {q, c2};
         end
      end
      send_chunk(q);
   endtask

   always @(negedge clock)
      rsp_stall <= receiver_stalls ? ($urandom_range(99) < idle_pct) : 1'b0;

   always @(posedge clock) begin
      span_type got_span, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_span = '{rsp_row, rsp_column, rsp_span_length, rsp_value_first,
                      rsp_value_second, rsp_alternate, rsp_clear_all, rsp_row_error};
         spans_seen++;
         if (span_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected span: row %0d col %0d len %0d", rsp_row, rsp_column,
                        rsp_span_length);
         end else begin
            want = span_queue.pop_front();
            if (got_span !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("span mismatch: exp row %0d col %0d len %0d v %h/%h alt %b clr %b err %b",
                           want.row, want.column, want.span_length, want.value_first,
                           want.value_second, want.alternate, want.clear_all, want.row_error);
                  $display("               got row %0d col %0d len %0d v %h/%h alt %b clr %b err %b",
                           got_span.row, got_span.column, got_span.span_length,
                           got_span.value_first, got_span.value_second, got_span.alternate,
                           got_span.clear_all, got_span.row_error);
               end
            end
         end
      end
   end

   initial begin
      #1000000;
      $display("[flic_pixel_chunk_decoder_unit] ERROR");
      $finish;
   end

   table_row_type directed[$];

   function automatic span_type typed_span(int r, int c, int len, int v, bit clr, bit err);
      span_type s;
      s = '0;
      s.row = 12'(r);
      s.column = 12'(c);
      s.span_length = 9'(len);
      s.value_first = 8'(v);
      s.clear_all = clr;
      s.row_error = err;
      return s;
   endfunction

   initial begin
      cfg_width = 320;
      cfg_height = 200;
      phase = PH_IDLE;
      err_latched = 0;
      directed = '{
         '{FUNC_BLACK, 1, 8'h00, ExpTyped, typed_span(0, 0, 0, 0, 1, 0)},
         '{FUNC_BRUN,  0, 8'hFF, ExpNone,  '0},
         '{3'd5,       1, 8'hFF, ExpNone,  '0},
         '{3'd7,       1, 8'h00, ExpNone,  '0},
         '{FUNC_BRUN,  1, 8'h00, ExpNone,  '0},
         '{3'd6,       0, 8'h7F, ExpNone,  '0},
         '{FUNC_BRUN,  0, 8'hAB, ExpTyped, typed_span(0, 0, 127, 8'hAB, 0, 0)},
         '{FUNC_BRUN,  0, 8'hFF, ExpModel, '0},
         '{FUNC_BRUN,  0, 8'h12, ExpModel, '0},
         '{FUNC_LC,    1, 8'hC8, ExpNone,  '0},
         '{FUNC_LC,    0, 8'h00, ExpNone,  '0},
         '{FUNC_LC,    0, 8'h01, ExpNone,  '0},
         '{FUNC_LC,    0, 8'h00, ExpNone,  '0},
         '{FUNC_LC,    0, 8'h01, ExpTyped, typed_span(200, 0, 0, 0, 0, 1)},
         '{FUNC_LC,    0, 8'h05, ExpNone,  '0},
         '{FUNC_SS2,   1, 8'h01, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'h00, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'h55, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'h80, ExpTyped, typed_span(0, 319, 1, 8'h55, 0, 0)},
         '{FUNC_SS2,   0, 8'h01, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'h00, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'h00, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'hFF, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'h11, ExpNone,  '0},
         '{FUNC_SS2,   0, 8'h22, ExpModel, '0},
         '{FUNC_COPY,  1, 8'hFF, ExpTyped, typed_span(0, 0, 1, 8'hFF, 0, 0)}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (directed[i])
         send_byte(directed[i].func, directed[i].start, directed[i].data, directed[i].how,
                   directed[i].span);
      for (int p = 0; p < 12; p++) begin
         int goal;
         @(negedge clock);
         req_valid <= 0;
         drain();
         sender_idles = p[0];
         receiver_stalls = p[1];
         idle_pct = (p[0] && p[1]) ? 28 : 58;
         case (p)
            0: begin write_csr(CSR_WIDTH, 320); write_csr(CSR_HEIGHT, 200); end
            1: begin write_csr(CSR_WIDTH, 1); write_csr(CSR_HEIGHT, 1); end
            2: begin write_csr(CSR_WIDTH, 4096); write_csr(CSR_HEIGHT, 4096); end
            3: begin write_csr(CSR_WIDTH, 0); write_csr(CSR_HEIGHT, 13'h1FFF); end
            default: begin
               write_csr(CSR_WIDTH, $urandom_range(2, 40));
               write_csr(CSR_HEIGHT, $urandom_range(1, 12));
            end
         endcase
         goal = items_sent + 135;
         while (items_sent < goal) random_chunk();
      end
      @(negedge clock);
      req_valid <= 0;
      drain();
      if (span_queue.size() != 0) mismatches++;
      $display("Sent %0d bytes in %0d chunks over 12 size and idling settings; %0d spans checked.",
               items_sent, chunks_sent, spans_seen);
      if (mismatches == 0) $display("[flic_pixel_chunk_decoder_unit] OK");
      else $display("[flic_pixel_chunk_decoder_unit] ERROR");
      $finish;
   end

endmodule
